>>> hw/rtl/lagged_cross_correlation_sums_top_defines.svh
// Assertion macros shared by the lagged cross-correlation sums checker.
`ifndef LAGGED_CROSS_CORRELATION_SUMS_TOP_DEFINES_SVH
`define LAGGED_CROSS_CORRELATION_SUMS_TOP_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define LCCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define LCCS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/lccs_pkg.sv
// Types and constants for the lagged cross-correlation sums block.
package lccs_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int SUM_W      = 64;
  localparam int SLOT_W     = 3;
  localparam int LAG_W      = 8;
  localparam int REQ_W      = 2;
  localparam int WLEN_W     = 7;
  localparam int LCNT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG_TABLE = 2'd2;

  localparam logic [WLEN_W-1:0] WAVE_LEN_RST  = 7'd64;
  localparam logic [LCNT_W-1:0] LAG_COUNT_RST = 4'd1;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] lag_slot;
    logic [SUM_W-1:0]  pair_count;
    logic [SUM_W-1:0]  total_a;
    logic [SUM_W-1:0]  total_b;
    logic [SUM_W-1:0]  total_aa;
    logic [SUM_W-1:0]  total_ab;
    logic [SUM_W-1:0]  total_bb;
    logic              final_slot;
  } out_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] pair_count;
    logic [SUM_W-1:0] total_a;
    logic [SUM_W-1:0] total_b;
    logic [SUM_W-1:0] total_aa;
    logic [SUM_W-1:0] total_ab;
    logic [SUM_W-1:0] total_bb;
  } sums_t;

  // Per-lane control from the top level's pipeline
  typedef struct packed {
    logic take;  // stage A item moves into stage B
    logic hit;   // the moving sample forms a pair at this lag
    logic add;   // stage B holds a sample: accumulate
    logic clr;   // stage B holds a clear: zero the sums
  } lane_ctl_t;

endpackage

>>> hw/rtl/lccs_lane.sv
// One lag slot: product registers and six saturating accumulators.
module lccs_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lccs_pkg::lane_ctl_t             ctl,
  input  logic [lccs_pkg::SAMPLE_W-1:0]   x,
  input  logic [lccs_pkg::SAMPLE_W-1:0]   y,
  output lccs_pkg::sums_t                 sums
);

  logic                          hit_r;
  logic [lccs_pkg::SAMPLE_W-1:0] x_r;
  logic [lccs_pkg::SAMPLE_W-1:0] y_r;
  logic [lccs_pkg::PROD_W-1:0]   xx_r;
  logic [lccs_pkg::PROD_W-1:0]   xy_r;
  logic [lccs_pkg::PROD_W-1:0]   yy_r;
  lccs_pkg::sums_t               sums_r;
  lccs_pkg::sums_t               sums_nxt;

  function automatic logic [lccs_pkg::SUM_W-1:0] sat_add(
    input logic [lccs_pkg::SUM_W-1:0] s,
    input logic [lccs_pkg::SUM_W-1:0] v
  );
    logic [lccs_pkg::SUM_W:0] t;
    t = {1'b0, s} + {1'b0, v};
    return t[lccs_pkg::SUM_W] ? '1 : t[lccs_pkg::SUM_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      hit_r <= ctl.hit;
      x_r   <= x;
      y_r   <= y;
      xx_r  <= lccs_pkg::PROD_W'(x) * lccs_pkg::PROD_W'(x);
      xy_r  <= lccs_pkg::PROD_W'(x) * lccs_pkg::PROD_W'(y);
      yy_r  <= lccs_pkg::PROD_W'(y) * lccs_pkg::PROD_W'(y);
    end
  end

  always_comb begin
    sums_nxt = sums_r;
    if (ctl.clr) begin
      sums_nxt = '0;
    end else if (ctl.add && hit_r) begin
      sums_nxt.pair_count = sat_add(sums_r.pair_count, lccs_pkg::SUM_W'(1));
      sums_nxt.total_a    = sat_add(sums_r.total_a, lccs_pkg::SUM_W'(x_r));
      sums_nxt.total_b    = sat_add(sums_r.total_b, lccs_pkg::SUM_W'(y_r));
      sums_nxt.total_aa   = sat_add(sums_r.total_aa, lccs_pkg::SUM_W'(xx_r));
      sums_nxt.total_ab   = sat_add(sums_r.total_ab, lccs_pkg::SUM_W'(xy_r));
      sums_nxt.total_bb   = sat_add(sums_r.total_bb, lccs_pkg::SUM_W'(yy_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r <= '0;
    end else begin
      sums_r <= sums_nxt;
    end
  end

  assign sums = sums_r;

endmodule

>>> hw/rtl/lagged_cross_correlation_sums_top.sv
// Top level of the lagged cross-correlation moment accumulator.
//
// Usage:
//   in_*  : one transaction per request. req_type selects a sample pair,
//           a readout of the per-lag sums, or a clear of sums and position.
//           Code 3 passes through and does nothing.
//   out_* : a readout yields one transaction per lag slot in use, slot 0
//           first, final_slot set on the last one.
//   cfg_* : write wave_len, lag_count or lag_table while the block is idle.
// Throughput: one sample pair or clear per cycle while nothing stalls.
//   A readout occupies the result stage until each slot in use is sent,
//   one slot per cycle from the output register unless out_stall is
//   high, and holds later requests behind it.
// Pipeline: stage A (input register, lag taps, products), then stage B
//   (saturating adds, slot counter), then the out_valid/out_data register.
// Reset: clears sums, wave position, pipeline valids and configuration
//   (wave_len 64, lag_count 1, all lags zero). The sample delay lines
//   need no reset: a tap is used only once written in the same waveform.
// Stall: out_stall holds the output register; in_stall rises once the
//   readout in stage B cannot advance, and the pipeline holds behind it.
module lagged_cross_correlation_sums_top #(
  parameter int WAVE_LEN = 64,
  parameter int NUM_LAGS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lccs_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lccs_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [lccs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [lccs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int POS_W  = $clog2(WAVE_LEN);
  localparam int CMP_W  = (POS_W + 1 > lccs_pkg::LAG_W) ? POS_W + 1 : lccs_pkg::LAG_W;
  localparam int HIST_D = WAVE_LEN - 1;
  localparam int SIDX_W = (NUM_LAGS > 1) ? $clog2(NUM_LAGS) : 1;

  // Configuration registers
  logic [lccs_pkg::WLEN_W-1:0]     wave_len_r;
  logic [lccs_pkg::LCNT_W-1:0]     lag_count_r;
  logic [lccs_pkg::CFG_DATA_W-1:0] lag_table_r;

  // Pipeline registers
  logic                            a_valid_r;
  lccs_pkg::in_item_t              a_r;
  logic                            b_valid_r;
  logic [lccs_pkg::REQ_W-1:0]      b_req_r;
  logic [POS_W-1:0]                pos_r;
  logic [POS_W-1:0]                pos_nxt;
  logic [lccs_pkg::SLOT_W-1:0]     slot_r;
  logic                            out_valid_r;
  lccs_pkg::out_item_t             out_data_r;

  // Delay lines: entry 0 holds the previous sample of this stream
  logic [lccs_pkg::SAMPLE_W-1:0]   hist_a_r [HIST_D];
  logic [lccs_pkg::SAMPLE_W-1:0]   hist_b_r [HIST_D];
  logic [lccs_pkg::SAMPLE_W-1:0]   tap_a [WAVE_LEN];
  logic [lccs_pkg::SAMPLE_W-1:0]   tap_b [WAVE_LEN];

  logic [CMP_W-1:0]                eff_len;
  logic [lccs_pkg::LCNT_W-1:0]     eff_lags;
  logic [CMP_W-1:0]                p_cmp;
  logic [CMP_W-1:0]                p_inc;

  logic                            a_sample;
  logic                            a_clear;
  logic                            a_move;
  logic                            in_acc;
  logic                            b_read;
  logic                            b_done;
  logic                            out_free;
  logic                            out_load;
  logic                            read_last;

  lccs_pkg::sums_t                 lane_sums [NUM_LAGS];
  lccs_pkg::sums_t                 rd_sums;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_len_r  <= lccs_pkg::WAVE_LEN_RST;
      lag_count_r <= lccs_pkg::LAG_COUNT_RST;
      lag_table_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lccs_pkg::CFG_WAVE_LEN:  wave_len_r  <= cfg_wdata[lccs_pkg::WLEN_W-1:0];
        lccs_pkg::CFG_LAG_COUNT: lag_count_r <= cfg_wdata[lccs_pkg::LCNT_W-1:0];
        lccs_pkg::CFG_LAG_TABLE: lag_table_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp wave length and lag count to their usable ranges
  always_comb begin
    eff_len = CMP_W'(wave_len_r);
    if (eff_len < CMP_W'(2)) begin
      eff_len = CMP_W'(2);
    end else if (eff_len > CMP_W'(WAVE_LEN)) begin
      eff_len = CMP_W'(WAVE_LEN);
    end
    eff_lags = lag_count_r;
    if (eff_lags == '0) begin
      eff_lags = lccs_pkg::LCNT_W'(1);
    end else if (eff_lags > lccs_pkg::LCNT_W'(NUM_LAGS)) begin
      eff_lags = lccs_pkg::LCNT_W'(NUM_LAGS);
    end
  end

  // Position of the sample in stage A; restart the waveform if the
  // length shrank to or below the stored position
  always_comb begin
    p_cmp   = (CMP_W'(pos_r) < eff_len) ? CMP_W'(pos_r) : '0;
    p_inc   = p_cmp + CMP_W'(1);
    pos_nxt = (p_inc >= eff_len) ? '0 : p_inc[POS_W-1:0];
  end

  // Tap 0 is the sample in stage A itself
  always_comb begin
    tap_a[0] = a_r.sample_a;
    tap_b[0] = a_r.sample_b;
    for (int i = 1; i < WAVE_LEN; i++) begin
      tap_a[i] = hist_a_r[i-1];
      tap_b[i] = hist_b_r[i-1];
    end
  end

  // Handshake and pipeline flow
  assign a_sample  = a_r.req_type == lccs_pkg::REQ_SAMPLE;
  assign a_clear   = a_r.req_type == lccs_pkg::REQ_CLEAR;
  assign out_free  = !out_valid_r || !out_stall;
  assign b_read    = b_valid_r && (b_req_r == lccs_pkg::REQ_READ);
  assign read_last = {1'b0, slot_r} == (eff_lags - lccs_pkg::LCNT_W'(1));
  assign out_load  = b_read && out_free;
  assign b_done    = !b_read || (out_free && read_last);
  assign a_move    = a_valid_r && b_done;
  assign in_stall  = a_valid_r && !b_done;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (!a_valid_r || b_done) begin
        a_valid_r <= in_valid;
      end
      if (b_done) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r <= in_data;
    end
    if (b_done) begin
      b_req_r <= a_r.req_type;
    end
  end

  // Advance position on a sample, drop it to zero on a clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (a_move && a_sample) begin
      pos_r <= pos_nxt;
    end else if (a_move && a_clear) begin
      pos_r <= '0;
    end
  end

  // Shift the delay lines on each sample
  always_ff @(posedge clk) begin
    if (a_move && a_sample) begin
      hist_a_r[0] <= a_r.sample_a;
      hist_b_r[0] <= a_r.sample_b;
      for (int i = 1; i < HIST_D; i++) begin
        hist_a_r[i] <= hist_a_r[i-1];
        hist_b_r[i] <= hist_b_r[i-1];
      end
    end
  end

  // One lane per lag slot, all updated in the same cycle
  for (genvar k = 0; k < NUM_LAGS; k++) begin : g_lane
    logic [lccs_pkg::LAG_W-1:0]    lag;
    logic [lccs_pkg::LAG_W-1:0]    mag;
    logic [CMP_W-1:0]              mag_cmp;
    logic [POS_W-1:0]              tap_idx;
    logic [lccs_pkg::SAMPLE_W-1:0] dly;
    logic [lccs_pkg::SAMPLE_W-1:0] x;
    logic [lccs_pkg::SAMPLE_W-1:0] y;
    lccs_pkg::lane_ctl_t           ctl;

    always_comb begin
      lag     = lag_table_r[lccs_pkg::LAG_W*k +: lccs_pkg::LAG_W];
      // Negative lag: pair a delayed with b current
      mag     = lag[lccs_pkg::LAG_W-1] ? (~lag + lccs_pkg::LAG_W'(1)) : lag;
      mag_cmp = CMP_W'(mag);
      tap_idx = (mag_cmp < CMP_W'(WAVE_LEN)) ? mag[POS_W-1:0] : '0;
      dly     = lag[lccs_pkg::LAG_W-1] ? tap_a[tap_idx] : tap_b[tap_idx];
      x       = lag[lccs_pkg::LAG_W-1] ? dly : a_r.sample_a;
      y       = lag[lccs_pkg::LAG_W-1] ? a_r.sample_b : dly;
      ctl.take = a_move;
      ctl.hit  = a_sample && (lccs_pkg::LCNT_W'(k) < eff_lags) && (mag_cmp <= p_cmp);
      ctl.add  = b_valid_r && (b_req_r == lccs_pkg::REQ_SAMPLE);
      ctl.clr  = b_valid_r && (b_req_r == lccs_pkg::REQ_CLEAR);
    end

    lccs_lane u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .x    (x),
      .y    (y),
      .sums (lane_sums[k])
    );
  end

  // Readout: step the slot counter once per delivered transaction
  assign rd_sums = lane_sums[slot_r[SIDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (out_load) begin
      slot_r <= read_last ? '0 : slot_r + lccs_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= b_read;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r.lag_slot   <= slot_r;
      out_data_r.pair_count <= rd_sums.pair_count;
      out_data_r.total_a    <= rd_sums.total_a;
      out_data_r.total_b    <= rd_sums.total_b;
      out_data_r.total_aa   <= rd_sums.total_aa;
      out_data_r.total_ab   <= rd_sums.total_ab;
      out_data_r.total_bb   <= rd_sums.total_bb;
      out_data_r.final_slot <= read_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/lccs_checker.sv
// Port-level checker for the lagged cross-correlation sums block, with its bind.
`include "lagged_cross_correlation_sums_top_defines.svh"

module lccs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input lccs_pkg::out_item_t out_data
);

  `LCCS_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "result valid right after reset")

  `LCCS_ASSERT(a_slot_step, out_valid && !out_stall && !out_data.final_slot |=> out_valid && (out_data.lag_slot == $past(out_data.lag_slot) + 1'b1), "readout slot did not advance")

  `LCCS_ASSERT(a_slot_restart, out_valid && !out_stall && out_data.final_slot |=> !out_valid || (out_data.lag_slot == '0), "readout did not restart at slot zero")

  `LCCS_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

endmodule

bind lagged_cross_correlation_sums_top lccs_checker u_lccs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
